// File: rtl/core/dpl_pkg.sv
// Shared constants, types and the sequencer state encoding for the demand-paging translator.
// Used by every file under rtl/core except dpl_ram; depends on nothing.
package dpl_pkg;

  localparam int VA_W        = 18;
  localparam int PA_W        = 16;
  localparam int CNT_W       = 32;
  localparam int SHIFT_W     = 4;
  localparam int PAGE_NUM_W  = 14;
  localparam int OFFSET_W    = 12;
  localparam int MAX_FRAME_W = 8;
  localparam int COMPOSE_W   = MAX_FRAME_W + OFFSET_W;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd12;

  localparam int VIRTUAL_PAGES_DEF   = 64;
  localparam int PHYSICAL_FRAMES_DEF = 16;

  typedef struct packed {
    logic [PAGE_NUM_W-1:0] page_num;
    logic                  out_of_range;
  } split_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PT_CHECK,
    S_EV_STACK,
    S_EV_TABLE,
    S_EV_LOAD,
    S_SCAN_START,
    S_SCAN,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/dpl_in_if.sv
// Request channel carrying one virtual address per transfer.
// Depends on dpl_pkg for the field width.
interface dpl_in_if;
  logic                       valid;
  logic                       ready;
  logic [dpl_pkg::VA_W-1:0]   virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

// File: rtl/core/dpl_out_if.sv
// Response channel carrying one translation result per transfer.
// Depends on dpl_pkg for the field widths.
interface dpl_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpl_pkg::PA_W-1:0]    physical_address;
  logic                        page_fault;
  logic                        out_of_range;
  logic [dpl_pkg::CNT_W-1:0]   fault_count;
  logic [dpl_pkg::CNT_W-1:0]   access_count;

  modport source (output valid, output physical_address, output page_fault,
                  output out_of_range, output fault_count, output access_count, input ready);
  modport sink (input valid, input physical_address, input page_fault,
                input out_of_range, input fault_count, input access_count, output ready);
endinterface

// File: rtl/core/dpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the page table and the recency stack.
module dpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dpl_addr.sv
// Address splitter and physical address composer.
// Clamps the page shift, splits the virtual address and joins frame and offset; uses dpl_pkg.
module dpl_addr #(
  parameter int VIRTUAL_PAGES = dpl_pkg::VIRTUAL_PAGES_DEF
) (
  input  logic [dpl_pkg::VA_W-1:0]        virtual_address,
  input  logic [dpl_pkg::SHIFT_W-1:0]     page_shift,
  input  logic [dpl_pkg::MAX_FRAME_W-1:0] frame,
  output dpl_pkg::split_t                 split,
  output logic [dpl_pkg::PA_W-1:0]        physical_address
);

  logic [dpl_pkg::SHIFT_W-1:0]   shift;
  logic [dpl_pkg::VA_W-1:0]      shifted;
  logic [dpl_pkg::VA_W-1:0]      mask;
  logic [dpl_pkg::OFFSET_W-1:0]  offset;
  logic [dpl_pkg::COMPOSE_W-1:0] composed;

  always_comb begin
    if (page_shift < dpl_pkg::SHIFT_MIN) begin
      shift = dpl_pkg::SHIFT_MIN;
    end else if (page_shift > dpl_pkg::SHIFT_MAX) begin
      shift = dpl_pkg::SHIFT_MAX;
    end else begin
      shift = page_shift;
    end
    shifted = virtual_address >> shift;
    mask = (dpl_pkg::VA_W'(1) << shift) - dpl_pkg::VA_W'(1);
    offset = dpl_pkg::OFFSET_W'(virtual_address & mask);
    split.page_num = shifted[dpl_pkg::PAGE_NUM_W-1:0];
    split.out_of_range = (32'(split.page_num) >= 32'(VIRTUAL_PAGES));
    composed = (dpl_pkg::COMPOSE_W'(frame) << shift) | dpl_pkg::COMPOSE_W'(offset);
    physical_address = composed[dpl_pkg::PA_W-1:0];
  end

endmodule

// File: rtl/core/demand_paging_lru_translate.sv
// Demand-paging address translator with least-recently-used frame replacement.
// Instantiates dpl_addr and two dpl_ram; uses dpl_pkg, dpl_in_if and dpl_out_if.
//
// Usage: addr_req carries one virtual address per transfer, xlat_rsp one result per
// transfer (physical address, fault flag, out-of-range flag, running fault and access
// counts). The page size is set through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. After reset
// the page table is cleared one entry per cycle, with addr_req.ready low until every
// entry is cleared; the page shift register returns to 12. Frames are handed out
// lowest first, so frame allocation is a fill count. One request is handled at a time.
// On a hit the recency stack is searched and shifted one entry per cycle through a
// single compare unit and the stack memory port, up to the page's position. A fault
// walks all stack entries and then inserts, after first evicting the least recently
// used page when no frame is free. An out-of-range address goes from decode straight
// to the result register and changes no state. The result register frees the engine:
// a new request is taken while a result waits, and a stalled receiver only holds the
// engine once the next result is ready to be loaded.
module demand_paging_lru_translate #(
  parameter int VIRTUAL_PAGES   = dpl_pkg::VIRTUAL_PAGES_DEF,
  parameter int PHYSICAL_FRAMES = dpl_pkg::PHYSICAL_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dpl_pkg::SHIFT_W-1:0]    cfg_wr_data,
  dpl_in_if.sink                         addr_req,
  dpl_out_if.source                      xlat_rsp
);

  localparam int PW = $clog2(VIRTUAL_PAGES);
  localparam int FW = (PHYSICAL_FRAMES > 1) ? $clog2(PHYSICAL_FRAMES) : 1;
  localparam int CW = $clog2(PHYSICAL_FRAMES + 1);
  localparam int EW = FW + 1;

  dpl_pkg::state_t state, state_next;

  logic [dpl_pkg::SHIFT_W-1:0] page_shift;
  logic [dpl_pkg::VA_W-1:0]    va;
  logic [FW-1:0]               frame;
  logic [PW-1:0]               victim;
  logic [PW-1:0]               carry;
  logic [FW-1:0]               idx;
  logic [PW-1:0]               clr_idx;
  logic [CW-1:0]               used_cnt;
  logic [CW-1:0]               rec_cnt;
  logic [dpl_pkg::CNT_W-1:0]   fault_cnt;
  logic [dpl_pkg::CNT_W-1:0]   access_cnt;
  logic                        fault;
  logic                        oor;
  logic                        rsp_valid;
  logic                        rsp_load;

  dpl_pkg::split_t             split;
  logic [dpl_pkg::PA_W-1:0]    pa;
  logic [PW-1:0]               page;

  logic                        pt_we;
  logic [PW-1:0]               pt_waddr;
  logic [EW-1:0]               pt_wdata;
  logic [PW-1:0]               pt_raddr;
  logic [EW-1:0]               pt_rdata;
  logic                        st_we;
  logic [FW-1:0]               st_waddr;
  logic [PW-1:0]               st_wdata;
  logic [FW-1:0]               st_raddr;
  logic [PW-1:0]               st_rdata;

  logic                        frame_free;
  logic                        scan_last;

  dpl_addr #(
    .VIRTUAL_PAGES (VIRTUAL_PAGES)
  ) u_addr (
    .virtual_address  (va),
    .page_shift       (page_shift),
    .frame            (dpl_pkg::MAX_FRAME_W'(frame)),
    .split            (split),
    .physical_address (pa)
  );

  dpl_ram #(
    .WIDTH (EW),
    .DEPTH (VIRTUAL_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  dpl_ram #(
    .WIDTH (PW),
    .DEPTH (PHYSICAL_FRAMES)
  ) u_recency (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign page = split.page_num[PW-1:0];
  assign frame_free = (used_cnt < CW'(PHYSICAL_FRAMES));
  assign scan_last = ((CW'(idx) + CW'(1)) == rec_cnt);
  assign rsp_load = (state == dpl_pkg::S_DONE) && (!rsp_valid || xlat_rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpl_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_req.ready = 1'b0;
    pt_we = 1'b0;
    pt_waddr = page;
    pt_wdata = {1'b1, frame};
    pt_raddr = page;
    st_we = 1'b0;
    st_waddr = idx;
    st_wdata = carry;
    st_raddr = idx;
    unique case (state)
      dpl_pkg::S_CLEAR: begin
        pt_we = 1'b1;
        pt_waddr = clr_idx;
        pt_wdata = '0;
        if (32'(clr_idx) == VIRTUAL_PAGES - 1) begin
          state_next = dpl_pkg::S_IDLE;
        end
      end
      dpl_pkg::S_IDLE: begin
        addr_req.ready = 1'b1;
        if (addr_req.valid) begin
          state_next = dpl_pkg::S_DECODE;
        end
      end
      dpl_pkg::S_DECODE: begin
        if (split.out_of_range) begin
          state_next = dpl_pkg::S_DONE;
        end else begin
          state_next = dpl_pkg::S_PT_CHECK;
        end
      end
      dpl_pkg::S_PT_CHECK: begin
        if (pt_rdata[FW]) begin
          state_next = dpl_pkg::S_SCAN_START;
        end else if (frame_free || rec_cnt == '0) begin
          state_next = dpl_pkg::S_EV_LOAD;
        end else begin
          st_raddr = FW'(rec_cnt - CW'(1));
          state_next = dpl_pkg::S_EV_STACK;
        end
      end
      dpl_pkg::S_EV_STACK: begin
        pt_raddr = st_rdata;
        state_next = dpl_pkg::S_EV_TABLE;
      end
      dpl_pkg::S_EV_TABLE: begin
        pt_we = 1'b1;
        pt_waddr = victim;
        pt_wdata = {1'b0, pt_rdata[FW-1:0]};
        state_next = dpl_pkg::S_EV_LOAD;
      end
      dpl_pkg::S_EV_LOAD: begin
        pt_we = 1'b1;
        state_next = dpl_pkg::S_SCAN_START;
      end
      dpl_pkg::S_SCAN_START: begin
        st_raddr = '0;
        if (rec_cnt == '0) begin
          state_next = dpl_pkg::S_INSERT;
        end else begin
          state_next = dpl_pkg::S_SCAN;
        end
      end
      dpl_pkg::S_SCAN: begin
        st_we = 1'b1;
        st_raddr = idx + FW'(1);
        if (st_rdata == page) begin
          state_next = dpl_pkg::S_DONE;
        end else if (scan_last) begin
          if (rec_cnt < CW'(PHYSICAL_FRAMES)) begin
            state_next = dpl_pkg::S_INSERT;
          end else begin
            state_next = dpl_pkg::S_DONE;
          end
        end
      end
      dpl_pkg::S_INSERT: begin
        st_we = 1'b1;
        st_waddr = rec_cnt[FW-1:0];
        state_next = dpl_pkg::S_DONE;
      end
      dpl_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = dpl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dpl_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= dpl_pkg::SHIFT_RESET;
    end else if (cfg_wr_en) begin
      page_shift <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      used_cnt <= '0;
      rec_cnt <= '0;
      fault_cnt <= '0;
      access_cnt <= '0;
    end else begin
      unique case (state)
        dpl_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + PW'(1);
        end
        dpl_pkg::S_DECODE: begin
          if (!split.out_of_range) begin
            access_cnt <= access_cnt + dpl_pkg::CNT_W'(1);
          end
        end
        dpl_pkg::S_PT_CHECK: begin
          if (!pt_rdata[FW]) begin
            fault_cnt <= fault_cnt + dpl_pkg::CNT_W'(1);
            if (frame_free) begin
              used_cnt <= used_cnt + CW'(1);
            end
          end
        end
        dpl_pkg::S_EV_TABLE: begin
          rec_cnt <= rec_cnt - CW'(1);
        end
        dpl_pkg::S_INSERT: begin
          rec_cnt <= rec_cnt + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dpl_pkg::S_IDLE: begin
        va <= addr_req.virtual_address;
      end
      dpl_pkg::S_DECODE: begin
        oor <= split.out_of_range;
        fault <= 1'b0;
      end
      dpl_pkg::S_PT_CHECK: begin
        if (pt_rdata[FW]) begin
          frame <= pt_rdata[FW-1:0];
        end else begin
          fault <= 1'b1;
          if (frame_free) begin
            frame <= used_cnt[FW-1:0];
          end else begin
            frame <= '0;
          end
        end
      end
      dpl_pkg::S_EV_STACK: begin
        victim <= st_rdata;
      end
      dpl_pkg::S_EV_TABLE: begin
        frame <= pt_rdata[FW-1:0];
      end
      dpl_pkg::S_SCAN_START: begin
        carry <= page;
        idx <= '0;
      end
      dpl_pkg::S_SCAN: begin
        carry <= st_rdata;
        idx <= idx + FW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (xlat_rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      xlat_rsp.out_of_range <= oor;
      if (oor) begin
        xlat_rsp.physical_address <= '0;
        xlat_rsp.page_fault <= 1'b0;
        xlat_rsp.fault_count <= '0;
        xlat_rsp.access_count <= '0;
      end else begin
        xlat_rsp.physical_address <= pa;
        xlat_rsp.page_fault <= fault;
        xlat_rsp.fault_count <= fault_cnt;
        xlat_rsp.access_count <= access_cnt;
      end
    end
  end

  assign xlat_rsp.valid = rsp_valid;

endmodule

// File: tb/sv/tb_demand_paging_lru_translate.sv
// Self-checking bench for demand_paging_lru_translate: a directed table, then random
// address streams checked against an LRU paging predictor kept inside this module.
// Depends on dpl_pkg, dpl_in_if, dpl_out_if and the translator RTL.
module tb_demand_paging_lru_translate;

  localparam int PAGES = dpl_pkg::VIRTUAL_PAGES_DEF;
  localparam int FRAMES = dpl_pkg::PHYSICAL_FRAMES_DEF;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int PHASE_ITEMS = 123;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [dpl_pkg::PA_W-1:0]  physical_address;
    logic                      page_fault;
    logic                      out_of_range;
    logic [dpl_pkg::CNT_W-1:0] fault_count;
    logic [dpl_pkg::CNT_W-1:0] access_count;
  } xlat_t;

  typedef enum logic {ROW_CFG, ROW_XLAT} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [dpl_pkg::VA_W-1:0] value;
    logic                     typed;
    xlat_t                    result;
  } row_t;

  localparam xlat_t NONE = '0;
  localparam xlat_t OOR = '{16'h0000, 1'b0, 1'b1, 32'd0, 32'd0};

  localparam int DIR_ROWS = 25;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_XLAT, 18'h00000, 1'b1, '{16'h0000, 1'b1, 1'b0, 32'd1, 32'd1}},
    '{ROW_XLAT, 18'h3FFFF, 1'b1, '{16'h1FFF, 1'b1, 1'b0, 32'd2, 32'd2}},
    '{ROW_XLAT, 18'h00FFF, 1'b1, '{16'h0FFF, 1'b0, 1'b0, 32'd2, 32'd3}},
    '{ROW_CFG,  18'h00000, 1'b0, NONE},
    '{ROW_XLAT, 18'h3FFFF, 1'b1, OOR},
    '{ROW_XLAT, 18'h00400, 1'b1, OOR},
    '{ROW_XLAT, 18'h003F5, 1'b1, '{16'h0015, 1'b0, 1'b0, 32'd2, 32'd4}},
    '{ROW_XLAT, 18'h0001F, 1'b0, NONE},
    '{ROW_XLAT, 18'h00020, 1'b0, NONE},
    '{ROW_XLAT, 18'h0003A, 1'b0, NONE},
    '{ROW_XLAT, 18'h00041, 1'b0, NONE},
    '{ROW_XLAT, 18'h0005C, 1'b0, NONE},
    '{ROW_XLAT, 18'h00067, 1'b0, NONE},
    '{ROW_XLAT, 18'h00070, 1'b0, NONE},
    '{ROW_XLAT, 18'h0008E, 1'b0, NONE},
    '{ROW_XLAT, 18'h00093, 1'b0, NONE},
    '{ROW_XLAT, 18'h000A5, 1'b0, NONE},
    '{ROW_XLAT, 18'h000BF, 1'b0, NONE},
    '{ROW_XLAT, 18'h000C0, 1'b0, NONE},
    '{ROW_XLAT, 18'h000D8, 1'b0, NONE},
    '{ROW_XLAT, 18'h000E1, 1'b0, NONE},
    '{ROW_XLAT, 18'h00149, 1'b0, NONE},
    '{ROW_XLAT, 18'h00006, 1'b0, NONE},
    '{ROW_CFG,  18'h0000F, 1'b0, NONE},
    '{ROW_XLAT, 18'h3F000, 1'b0, NONE}
  };

  localparam int PHASES = 10;
  localparam logic [dpl_pkg::SHIFT_W-1:0] PHASE_SHIFTS [PHASES] = '{
    4'd12, 4'd4, 4'd7, 4'd13, 4'd3, 4'd10, 4'd5, 4'd15, 4'd6, 4'd0
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [dpl_pkg::SHIFT_W-1:0] cfg_wr_data;

  dpl_in_if addr_req ();
  dpl_out_if xlat_rsp ();

  demand_paging_lru_translate dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .addr_req   (addr_req),
    .xlat_rsp   (xlat_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic page_resident [PAGES];
  logic [FRAME_W-1:0] page_to_frame [PAGES];
  logic frame_taken [FRAMES];
  logic [PAGE_W-1:0] lru_order [FRAMES];
  int lru_depth;
  logic [dpl_pkg::CNT_W-1:0] faults_so_far;
  logic [dpl_pkg::CNT_W-1:0] accesses_so_far;
  logic [dpl_pkg::SHIFT_W-1:0] shift_setting;

  xlat_t pending_xlat [$];
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  function automatic int page_bits();
    if (shift_setting < dpl_pkg::SHIFT_MIN) return int'(dpl_pkg::SHIFT_MIN);
    if (shift_setting > dpl_pkg::SHIFT_MAX) return int'(dpl_pkg::SHIFT_MAX);
    return int'(shift_setting);
  endfunction

  function automatic xlat_t translate_address(logic [dpl_pkg::VA_W-1:0] va);
    xlat_t r;
    int sh;
    int page;
    int frame;
    int victim;
    int pos;
    bit found;
    r = '0;
    sh = page_bits();
    page = int'(va) >> sh;
    if (page >= PAGES) begin
      r.out_of_range = 1'b1;
      return r;
    end
    accesses_so_far++;
    if (!page_resident[page]) begin
      r.page_fault = 1'b1;
      faults_so_far++;
      frame = 0;
      found = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        if (!found && !frame_taken[i]) begin
          frame = i;
          found = 1'b1;
        end
      end
      if (!found && lru_depth > 0) begin
        lru_depth--;
        victim = int'(lru_order[lru_depth]);
        frame = int'(page_to_frame[victim]);
        page_resident[victim] = 1'b0;
      end
      page_to_frame[page] = FRAME_W'(frame);
      page_resident[page] = 1'b1;
      frame_taken[frame] = 1'b1;
    end
    pos = 0;
    while (pos < lru_depth && lru_order[pos] != PAGE_W'(page)) pos++;
    if (pos == lru_depth) begin
      if (lru_depth < FRAMES) lru_depth++;
      else pos = FRAMES - 1;
    end
    for (int k = pos; k > 0; k--) lru_order[k] = lru_order[k - 1];
    lru_order[0] = PAGE_W'(page);
    r.physical_address = dpl_pkg::PA_W'((int'(page_to_frame[page]) << sh) |
                                        (int'(va) & ((1 << sh) - 1)));
    r.fault_count = faults_so_far;
    r.access_count = accesses_so_far;
    return r;
  endfunction

  function automatic logic [dpl_pkg::VA_W-1:0] address_in_page(int page);
    int sh;
    sh = page_bits();
    return dpl_pkg::VA_W'((page << sh) | ($urandom & ((1 << sh) - 1)));
  endfunction

  task automatic report_mismatch(string what, logic [dpl_pkg::CNT_W-1:0] got,
                                 logic [dpl_pkg::CNT_W-1:0] want);
    $display("mismatch on result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  task automatic offer_address(logic [dpl_pkg::VA_W-1:0] va, int gap, logic typed,
                               xlat_t want);
    xlat_t predicted;
    if (gap > 0) begin
      addr_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    addr_req.valid <= 1'b1;
    addr_req.virtual_address <= va;
    do @(posedge clk); while (!addr_req.ready);
    predicted = translate_address(va);
    pending_xlat.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    addr_req.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_page_shift(logic [dpl_pkg::SHIFT_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shift_setting = value;
  endtask

  initial begin
    int gap_max;
    int ws;
    int base;
    int pick;
    logic [dpl_pkg::VA_W-1:0] va;
    for (int i = 0; i < PAGES; i++) begin
      page_resident[i] = 1'b0;
      page_to_frame[i] = '0;
    end
    for (int i = 0; i < FRAMES; i++) begin
      frame_taken[i] = 1'b0;
      lru_order[i] = '0;
    end
    lru_depth = 0;
    faults_so_far = '0;
    accesses_so_far = '0;
    shift_setting = dpl_pkg::SHIFT_RESET;
    ws = 2;
    base = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    addr_req.valid = 1'b0;
    addr_req.virtual_address = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        set_page_shift(DIRECTED[i].value[dpl_pkg::SHIFT_W-1:0]);
      end else begin
        offer_address(DIRECTED[i].value, $urandom_range(0, 3), DIRECTED[i].typed,
                      DIRECTED[i].result);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_page_shift(PHASE_SHIFTS[p]);
      gap_max = (p % 3 == 1) ? 0 : 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          ws = $urandom_range(2, 40);
          base = $urandom_range(0, PAGES - ws);
        end
        if (n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 85) va = address_in_page(base + $urandom_range(0, ws - 1));
        else if (pick < 92) va = address_in_page($urandom_range(0, PAGES - 1));
        else va = dpl_pkg::VA_W'($urandom);
        offer_address(va, $urandom_range(0, gap_max), 1'b0, NONE);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int gap;
    xlat_rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_seen == 300 || results_seen == 900) gap = HOLD_CYCLES;
      else if ((results_seen / 50) % 4 == 3) gap = 0;
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        xlat_rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      xlat_rsp.ready <= 1'b1;
      do @(posedge clk); while (!xlat_rsp.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    xlat_t want;
    if (!rst && xlat_rsp.valid && xlat_rsp.ready) begin
      if (pending_xlat.size() == 0) begin
        report_mismatch("unexpected transfer, out_of_range",
                        dpl_pkg::CNT_W'(xlat_rsp.out_of_range), '0);
      end else begin
        want = pending_xlat.pop_front();
        if (xlat_rsp.physical_address !== want.physical_address)
          report_mismatch("physical_address", dpl_pkg::CNT_W'(xlat_rsp.physical_address),
                          dpl_pkg::CNT_W'(want.physical_address));
        if (xlat_rsp.page_fault !== want.page_fault)
          report_mismatch("page_fault", dpl_pkg::CNT_W'(xlat_rsp.page_fault),
                          dpl_pkg::CNT_W'(want.page_fault));
        if (xlat_rsp.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", dpl_pkg::CNT_W'(xlat_rsp.out_of_range),
                          dpl_pkg::CNT_W'(want.out_of_range));
        if (xlat_rsp.fault_count !== want.fault_count)
          report_mismatch("fault_count", xlat_rsp.fault_count, want.fault_count);
        if (xlat_rsp.access_count !== want.access_count)
          report_mismatch("access_count", xlat_rsp.access_count, want.access_count);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((addr_req.valid && addr_req.ready) || (xlat_rsp.valid && xlat_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
